### rtl/core/ucf_pkg.sv
// Shared types, constants and table functions for the UTF-8 character folder.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package ucf_pkg;

    localparam int QueueDepth = 4;

    localparam int CpWidth = 21;

    localparam logic [7:0] QMARK = 8'h3F;

    // One decoded byte's worth of output: up to three bytes, in slot order.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            eos;
    } t_cmd;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first;
        logic [7:0] second;
    } t_fold;

    function automatic logic is_supported(input logic [CpWidth-1:0] cp);
        logic ok;
        ok = 1'b0;
        if (cp < 21'h00080) ok = 1'b1;
        if (cp >= 21'h000A1 && cp <= 21'h0017F) ok = 1'b1;
        if (cp >= 21'h03000 && cp <= 21'h030FF) ok = 1'b1;
        if (cp >= 21'h04E00 && cp <= 21'h09FFF) ok = 1'b1;
        if (cp >= 21'h0FF00 && cp <= 21'h0FF60) ok = 1'b1;
        if (cp == 21'h02026 || cp == 21'h02192 || cp == 21'h02103) ok = 1'b1;
        return ok;
    endfunction

    // Characters outside the supported ranges fold to ASCII; anything not
    // listed becomes a question mark.
    function automatic t_fold fold_lookup(input logic [CpWidth-1:0] cp);
        t_fold f;
        case (cp)
            21'h00218: f = {2'd1, "S", 8'h00};
            21'h00219: f = {2'd1, "s", 8'h00};
            21'h0021A: f = {2'd1, "T", 8'h00};
            21'h0021B: f = {2'd1, "t", 8'h00};
            21'h001C4: f = {2'd2, "D", "Z"};
            21'h001C5: f = {2'd2, "D", "z"};
            21'h001C6: f = {2'd2, "d", "z"};
            21'h001C7: f = {2'd2, "L", "J"};
            21'h001C8: f = {2'd2, "L", "j"};
            21'h001C9: f = {2'd2, "l", "j"};
            21'h001CA: f = {2'd2, "N", "J"};
            21'h001CB: f = {2'd2, "N", "j"};
            21'h001CC: f = {2'd2, "n", "j"};
            21'h00192: f = {2'd1, "f", 8'h00};
            21'h02019: f = {2'd1, 8'h27, 8'h00};
            21'h02018: f = {2'd1, 8'h27, 8'h00};
            21'h0201C: f = {2'd1, 8'h22, 8'h00};
            21'h0201D: f = {2'd1, 8'h22, 8'h00};
            21'h02013: f = {2'd1, "-", 8'h00};
            21'h02014: f = {2'd1, "-", 8'h00};
            21'h000A0: f = {2'd1, " ", 8'h00};
            default:   f = {2'd1, QMARK, 8'h00};
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ucf_front.sv
// Front end: UTF-8 decode state and classification of each input byte into a
// group of up to three output bytes. Depends on ucf_pkg.
`default_nettype none

module ucf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_end_of_string,
    input  wire logic          i_q_full,
    output logic               o_full,
    output logic               o_cmd_valid,
    output ucf_pkg::t_cmd      o_cmd
);
    import ucf_pkg::*;

    logic [2:0][7:0]     r_held,      n_held;
    logic [2:0]          r_seq_len,   n_seq_len;
    logic [1:0]          r_seen,      n_seen;
    logic [CpWidth-1:0]  r_cp,        n_cp;

    logic                accept;
    logic                is_cont;
    logic                complete;
    logic                start;
    logic [CpWidth-1:0]  cp_ext;
    logic [2:0]          lead_len;
    logic [CpWidth-1:0]  lead_cp;
    logic [2:0][7:0]     slots;
    logic [1:0]          cnt;
    t_fold               fold;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    always_comb begin
        n_held    = r_held;
        n_seq_len = r_seq_len;
        n_seen    = r_seen;
        n_cp      = r_cp;
        slots     = '0;
        cnt       = 2'd0;
        start     = 1'b0;

        is_cont  = (i_in_byte[7:6] == 2'b10);
        cp_ext   = {r_cp[CpWidth-7:0], i_in_byte[5:0]};
        complete = ({1'b0, r_seen} + 3'd1) >= r_seq_len;
        fold     = fold_lookup(cp_ext);

        if (i_in_byte[7:5] == 3'b110) begin
            lead_len = 3'd2;
            lead_cp  = {16'd0, i_in_byte[4:0]};
        end else if (i_in_byte[7:4] == 4'b1110) begin
            lead_len = 3'd3;
            lead_cp  = {17'd0, i_in_byte[3:0]};
        end else if (i_in_byte[7:3] == 5'b11110) begin
            lead_len = 3'd4;
            lead_cp  = {18'd0, i_in_byte[2:0]};
        end else begin
            lead_len = 3'd0;
            lead_cp  = '0;
        end

        if (r_seq_len == 3'd0) begin
            start = 1'b1;
        end else if (is_cont) begin
            if (complete) begin
                n_seq_len = 3'd0;
                n_seen    = 2'd0;
                n_cp      = '0;
                // Four-byte sequences always fold: only overlong forms could land
                // in a supported range.
                if (r_seq_len != 3'd4 && is_supported(cp_ext)) begin
                    if (r_seq_len == 3'd2) begin
                        slots[0] = r_held[0];
                        slots[1] = i_in_byte;
                        cnt      = 2'd2;
                    end else begin
                        slots[0] = r_held[0];
                        slots[1] = r_held[1];
                        slots[2] = i_in_byte;
                        cnt      = 2'd3;
                    end
                end else begin
                    slots[0] = fold.first;
                    slots[1] = fold.second;
                    cnt      = fold.count;
                end
            end else if (i_end_of_string) begin
                n_seq_len = 3'd0;
                n_seen    = 2'd0;
                n_cp      = '0;
                slots[0]  = QMARK;
                cnt       = 2'd1;
            end else begin
                if (r_seen != 2'd3) begin
                    n_held[r_seen] = i_in_byte;
                end
                n_seen = r_seen + 2'd1;
                n_cp   = cp_ext;
            end
        end else begin
            // A broken sequence gives up as a question mark, and the byte that
            // broke it is then decoded afresh.
            n_seq_len = 3'd0;
            n_seen    = 2'd0;
            n_cp      = '0;
            slots[0]  = QMARK;
            cnt       = 2'd1;
            start     = 1'b1;
        end

        if (start) begin
            if (i_in_byte[7] == 1'b0) begin
                slots[cnt] = i_in_byte;
                cnt        = cnt + 2'd1;
            end else if (lead_len != 3'd0) begin
                if (i_end_of_string) begin
                    slots[cnt] = QMARK;
                    cnt        = cnt + 2'd1;
                end else begin
                    n_held[0] = i_in_byte;
                    n_seq_len = lead_len;
                    n_seen    = 2'd1;
                    n_cp      = lead_cp;
                end
            end else begin
                slots[cnt] = QMARK;
                cnt        = cnt + 2'd1;
            end
        end

        if (i_end_of_string) begin
            n_seq_len = 3'd0;
            n_seen    = 2'd0;
            n_cp      = '0;
        end
    end

    assign o_cmd_valid = accept && (cnt != 2'd0);
    assign o_cmd.bytes = slots;
    assign o_cmd.count = cnt;
    assign o_cmd.eos   = i_end_of_string;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_seq_len <= 3'd0;
            r_seen    <= 2'd0;
            r_cp      <= '0;
        end else if (accept) begin
            r_held    <= n_held;
            r_seq_len <= n_seq_len;
            r_seen    <= n_seen;
            r_cp      <= n_cp;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ucf_queue.sv
// Short queue of byte groups between the decoder and the serialiser.
// Depends on ucf_pkg.
`default_nettype none

module ucf_queue #(
    parameter int DEPTH = ucf_pkg::QueueDepth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire ucf_pkg::t_cmd i_wr_data,
    input  wire logic          i_rd,
    output logic               o_full,
    output logic               o_empty,
    output ucf_pkg::t_cmd      o_head
);
    import ucf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            do_wr;
    logic            do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign do_wr = i_wr && !o_full;
    assign do_rd = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CW'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ucf_back.sv
// Back end: walks each queued byte group into the output register, one byte a cycle when
// it is free or popped, and marks the last byte of the group and of the string. Depends on ucf_pkg.
`default_nettype none

module ucf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire ucf_pkg::t_cmd i_q_head,
    output logic               o_q_rd,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_out_byte,
    output logic               o_item_done,
    output logic               o_string_done
);
    import ucf_pkg::*;

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_pos,       n_pos;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic        r_item_done, n_item_done;
    logic        r_str_done,  n_str_done;
    logic        load;
    logic        last;

    // The output register refills in the same cycle that it is popped, if the queue is not empty.
    assign load = !i_q_empty && (!r_out_valid || i_pop);
    assign last = (r_pos == i_q_head.count - 2'd1);

    always_comb begin
        n_out_valid = r_out_valid;
        n_pos       = r_pos;
        n_out_byte  = r_out_byte;
        n_item_done = r_item_done;
        n_str_done  = r_str_done;
        if (load) begin
            n_out_valid = 1'b1;
            n_out_byte  = i_q_head.bytes[r_pos];
            n_item_done = last;
            n_str_done  = last && i_q_head.eos;
            n_pos       = last ? 2'd0 : r_pos + 2'd1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_q_rd        = load && last;
    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_item_done   = r_item_done;
    assign o_string_done = r_str_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= 2'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_item_done <= n_item_done;
        r_str_done  <= n_str_done;
    end

endmodule

`default_nettype wire

### rtl/core/utf8_unsupported_char_folder_unit.sv
// Top level of the UTF-8 character folder: decoder, group queue and serialiser.
// Depends on ucf_pkg, ucf_front, ucf_queue and ucf_back.
//
//  Channel   Handshake            Payload
//  request   i_push / o_full      i_in_byte, i_end_of_string
//  result    o_empty / i_pop      o_out_byte, o_item_done, o_string_done
//
// A byte is taken every cycle while the group queue has room; it produces zero
// to three result bytes, which leave the output register at one a cycle while i_pop is held.
// A result is written to the group queue when its request is taken, then moves to the output
// register, from which it is on the result ports and can be popped.
// Reset is synchronous and closes any open sequence and empties the queue.
// Back-pressure on i_pop fills the queue and then raises o_full.
`default_nettype none

module utf8_unsupported_char_folder_unit #(
    parameter int QUEUE_DEPTH = ucf_pkg::QueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_string,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [7:0]       o_out_byte,
    output logic             o_item_done,
    output logic             o_string_done
);
    import ucf_pkg::*;

    t_cmd  cmd;
    t_cmd  head;
    logic  cmd_valid;
    logic  q_full;
    logic  q_empty;
    logic  q_rd;

    ucf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_q_full        (q_full),
        .o_full          (o_full),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd)
    );

    ucf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmd_valid),
        .i_wr_data (cmd),
        .i_rd      (q_rd),
        .o_full    (q_full),
        .o_empty   (q_empty),
        .o_head    (head)
    );

    ucf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_head      (head),
        .o_q_rd        (q_rd),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_out_byte    (o_out_byte),
        .o_item_done   (o_item_done),
        .o_string_done (o_string_done)
    );

endmodule

`default_nettype wire
